// File: hw/rtl/hrp_pkg.sv
`timescale 1ns / 1ps
package hrp_pkg;

   localparam int MAX_VERSION_DIGITS = 9;
   localparam int DCNT_W = $clog2(MAX_VERSION_DIGITS + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   typedef enum logic [4:0] {
      PH_METHOD, PH_METHOD_SP, PH_URL_FIRST, PH_URL, PH_HTTP,
      PH_MAJ_S, PH_MAJ_1, PH_MAJ_D, PH_MIN_S, PH_MIN_1, PH_MIN_D,
      PH_LINE, PH_NAME, PH_AFTER, PH_SPACES, PH_VALUE, PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      K_NONE     = 4'd0,
      K_METHOD   = 4'd1,
      K_URL      = 4'd2,
      K_VERSION  = 4'd3,
      K_NAME     = 4'd4,
      K_NAME_END = 4'd5,
      K_VALUE    = 4'd6,
      K_HDR_END  = 4'd7,
      K_DONE     = 4'd8,
      K_ERROR    = 4'd9
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] out_byte;
      logic [2:0] method;
      logic       last;
   } rsp_type;

   // all results of one request byte
   typedef struct packed {
      kind_type   kind0;
      logic [7:0] byte0;
      logic [2:0] meth0;
      logic       has2;
      logic [7:0] byte1;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [7:0] verb_char(input logic [2:0] idx, input logic [2:0] pos);
      logic [63:0] w;
      logic [5:0]  msb;
      case (idx)
         3'd0:    w = {"OPTIONS", 8'h00};
         3'd1:    w = {"GET", 40'h0};
         3'd2:    w = {"HEAD", 32'h0};
         3'd3:    w = {"POST", 32'h0};
         3'd4:    w = {"PUT", 40'h0};
         3'd5:    w = {"DELETE", 16'h0};
         3'd6:    w = {"TRACE", 24'h0};
         default: w = {"CONNECT", 8'h00};
      endcase
      msb = {~pos, 3'b111};
      return w[msb -: 8];
   endfunction

   function automatic logic [3:0] verb_len(input logic [2:0] idx);
      logic [3:0] n;
      case (idx)
         3'd0:    n = 4'd7;
         3'd1:    n = 4'd3;
         3'd2:    n = 4'd4;
         3'd3:    n = 4'd4;
         3'd4:    n = 4'd3;
         3'd5:    n = 4'd6;
         3'd6:    n = 4'd5;
         default: n = 4'd7;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] proto_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = "H";
         3'd1:    c = "T";
         3'd2:    c = "T";
         3'd3:    c = "P";
         default: c = "/";
      endcase
      return c;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_name_byte(input logic [7:0] b);
      logic ok;
      ok = (b >= 8'd32) && (b != CH_DEL);
      case (b)
         "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
         "{", "}", " ": ok = 1'b0;
         default: ;
      endcase
      return ok;
   endfunction

endpackage

// File: hw/rtl/hrp_front.sv
`timescale 1ns / 1ps
module hrp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  hrp_pkg::req_type   req,
   output hrp_pkg::group_type grp
);
   import hrp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [7:0]        cand_ff, cand_in;
   logic [2:0]        pos_ff, pos_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              pcr_ff, pcr_in;
   logic              err_ff, err_in;

   phase_type         c_phase;
   logic [7:0]        c_cand;
   logic [2:0]        c_pos;
   logic [DCNT_W-1:0] c_dcnt;
   logic              c_pcr;
   logic              c_err;
   logic [7:0]        b;
   logic [7:0]        keep;
   logic [7:0]        hit;
   logic [2:0]        hit_idx;
   logic              fail;
   logic              blank;

   assign b       = req.data_byte;
   assign c_phase = req.start_req ? PH_METHOD : phase_ff;
   assign c_cand  = req.start_req ? 8'hFF : cand_ff;
   assign c_pos   = req.start_req ? 3'd0 : pos_ff;
   assign c_dcnt  = req.start_req ? '0 : dcnt_ff;
   assign c_pcr   = req.start_req ? 1'b0 : pcr_ff;
   assign c_err   = req.start_req ? 1'b0 : err_ff;
   assign blank   = (b == CH_SP) || (b == CH_TAB);

   always_comb begin
      keep    = '0;
      hit     = '0;
      hit_idx = '0;
      for (int i = 0; i < 8; i++) begin
         keep[i] = c_cand[i] && ({1'b0, c_pos} < verb_len(3'(i)))
                   && (verb_char(3'(i), c_pos) == b);
         hit[i]  = keep[i] && (verb_len(3'(i)) == ({1'b0, c_pos} + 4'd1));
      end
      for (int i = 7; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = 3'(i);
         end
      end
   end

   // next state
   always_comb begin
      phase_in = c_phase;
      cand_in  = c_cand;
      pos_in   = c_pos;
      dcnt_in  = c_dcnt;
      pcr_in   = c_pcr;
      fail     = 1'b0;
      if (!c_err && (c_phase != PH_DONE)) begin
         if (c_pcr) begin
            pcr_in = 1'b0;
            case (c_phase)
               PH_MIN_D: begin
                  if (b != CH_LF) fail = 1'b1;
                  else phase_in = PH_LINE;
               end
               PH_LINE: begin
                  if (b != CH_LF) fail = 1'b1;
                  else phase_in = PH_DONE;
               end
               PH_AFTER: begin
                  if (b == CH_LF) begin
                     phase_in = PH_SPACES;
                  end else begin
                     phase_in = PH_VALUE;
                     pcr_in   = (b == CH_CR);
                  end
               end
               default: begin
                  if (b == CH_LF) begin
                     phase_in = PH_LINE;
                  end else begin
                     phase_in = PH_VALUE;
                     pcr_in   = (b == CH_CR);
                  end
               end
            endcase
         end else begin
            case (c_phase)
               PH_METHOD: begin
                  if (keep == '0) begin
                     fail = 1'b1;
                  end else begin
                     cand_in = keep;
                     if (hit != '0) phase_in = PH_METHOD_SP;
                     else pos_in = c_pos + 3'd1;
                  end
               end
               PH_METHOD_SP: begin
                  if (b != CH_SP) fail = 1'b1;
                  else phase_in = PH_URL_FIRST;
               end
               PH_URL_FIRST, PH_URL: begin
                  if (b == CH_SP) begin
                     if (c_phase == PH_URL_FIRST) begin
                        fail = 1'b1;
                     end else begin
                        phase_in = PH_HTTP;
                        pos_in   = 3'd0;
                     end
                  end else begin
                     phase_in = PH_URL;
                  end
               end
               PH_HTTP: begin
                  if ((c_pos > 3'd4) || (proto_char(c_pos) != b)) begin
                     fail = 1'b1;
                  end else begin
                     pos_in = c_pos + 3'd1;
                     if (c_pos == 3'd4) begin
                        phase_in = PH_MAJ_S;
                        dcnt_in  = '0;
                     end
                  end
               end
               PH_MAJ_S, PH_MIN_S: begin
                  if ((b == CH_PLUS) || (b == CH_MINUS)) begin
                     phase_in = (c_phase == PH_MAJ_S) ? PH_MAJ_1 : PH_MIN_1;
                  end else if (!is_digit(b) || (c_dcnt >= DCNT_W'(MAX_VERSION_DIGITS))) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = (c_phase == PH_MAJ_S) ? PH_MAJ_D : PH_MIN_D;
                     dcnt_in  = c_dcnt + DCNT_W'(1);
                  end
               end
               PH_MAJ_1, PH_MIN_1: begin
                  if (!is_digit(b) || (c_dcnt >= DCNT_W'(MAX_VERSION_DIGITS))) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = (c_phase == PH_MAJ_1) ? PH_MAJ_D : PH_MIN_D;
                     dcnt_in  = c_dcnt + DCNT_W'(1);
                  end
               end
               PH_MAJ_D, PH_MIN_D: begin
                  if (is_digit(b)) begin
                     if (c_dcnt >= DCNT_W'(MAX_VERSION_DIGITS)) fail = 1'b1;
                     else dcnt_in = c_dcnt + DCNT_W'(1);
                  end else if ((c_phase == PH_MAJ_D) && (b == CH_DOT)) begin
                     phase_in = PH_MIN_S;
                     dcnt_in  = '0;
                  end else if ((c_phase == PH_MIN_D) && (b == CH_CR)) begin
                     pcr_in = 1'b1;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_LINE: begin
                  if (b == CH_CR) pcr_in = 1'b1;
                  else if (is_name_byte(b)) phase_in = PH_NAME;
                  else fail = 1'b1;
               end
               PH_NAME: begin
                  if (b == CH_COLON) phase_in = PH_AFTER;
                  else if (!is_name_byte(b)) fail = 1'b1;
               end
               PH_AFTER: begin
                  if (b == CH_CR) begin
                     pcr_in = 1'b1;
                  end else if (blank) begin
                     phase_in = PH_SPACES;
                  end else begin
                     phase_in = PH_VALUE;
                  end
               end
               PH_SPACES, PH_VALUE: begin
                  if (!(blank && (c_phase == PH_SPACES))) begin
                     phase_in = PH_VALUE;
                     pcr_in   = (b == CH_CR);
                  end
               end
               default: ;
            endcase
         end
      end
      err_in = c_err || ((c_phase != PH_DONE)
               && (fail || (req.end_of_data && (phase_in != PH_DONE))));
   end

   // outputs
   always_comb begin
      grp       = '0;
      grp.kind0 = K_NONE;
      if (err_in) begin
         grp.kind0 = K_ERROR;
      end else if (c_phase == PH_DONE) begin
         grp.kind0 = K_NONE;
      end else if (c_pcr) begin
         case (c_phase)
            PH_MIN_D: grp.kind0 = K_NONE;
            PH_LINE:  grp.kind0 = K_DONE;
            default: begin
               if (b == CH_LF) begin
                  grp.kind0 = (c_phase == PH_AFTER) ? K_NONE : K_HDR_END;
               end else begin
                  grp.kind0 = K_VALUE;
                  grp.byte0 = CH_CR;
                  grp.has2  = (b != CH_CR);
                  grp.byte1 = b;
               end
            end
         endcase
      end else begin
         case (c_phase)
            PH_METHOD: begin
               if (hit != '0) begin
                  grp.kind0 = K_METHOD;
                  grp.meth0 = hit_idx;
               end
            end
            PH_URL_FIRST, PH_URL: begin
               if (b != CH_SP) begin
                  grp.kind0 = K_URL;
                  grp.byte0 = b;
               end
            end
            PH_MAJ_S, PH_MAJ_1, PH_MAJ_D, PH_MIN_S, PH_MIN_1, PH_MIN_D: begin
               if (b != CH_CR) begin
                  grp.kind0 = K_VERSION;
                  grp.byte0 = b;
               end
            end
            PH_LINE: begin
               if (b != CH_CR) begin
                  grp.kind0 = K_NAME;
                  grp.byte0 = b;
               end
            end
            PH_NAME: begin
               if (b == CH_COLON) begin
                  grp.kind0 = K_NAME_END;
               end else begin
                  grp.kind0 = K_NAME;
                  grp.byte0 = b;
               end
            end
            PH_AFTER, PH_SPACES: begin
               if ((b != CH_CR) && !blank) begin
                  grp.kind0 = K_VALUE;
                  grp.byte0 = b;
               end
            end
            PH_VALUE: begin
               if (b != CH_CR) begin
                  grp.kind0 = K_VALUE;
                  grp.byte0 = b;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_METHOD;
         cand_ff  <= 8'hFF;
         pos_ff   <= '0;
         dcnt_ff  <= '0;
         pcr_ff   <= 1'b0;
         err_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cand_ff  <= cand_in;
         pos_ff   <= pos_in;
         dcnt_ff  <= dcnt_in;
         pcr_ff   <= pcr_in;
         err_ff   <= err_in;
      end
   end

endmodule

// File: hw/rtl/hrp_queue.sv
`timescale 1ns / 1ps
module hrp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hrp_pkg::group_type  wr_grp,
   input  logic                pop,
   output hrp_pkg::group_type  rd_grp,
   output hrp_pkg::qstat_type  stat
);
   import hrp_pkg::*;

   group_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign stat.full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rd_grp     = mem_ff[rd_ff];

   assign wr_in  = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
   assign rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
   assign cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wr_grp;
      end
   end

endmodule

// File: hw/rtl/hrp_back.sv
`timescale 1ns / 1ps
module hrp_back (
   input  logic               clock,
   input  logic               reset,
   input  hrp_pkg::group_type grp,
   input  logic               grp_empty,
   input  logic               rsp_pop,
   output logic               grp_done,
   output hrp_pkg::rsp_type   rsp
);
   import hrp_pkg::*;

   logic sub_ff, sub_in;
   logic take;

   assign take = rsp_pop && !grp_empty;

   always_comb begin
      if (sub_ff) begin
         rsp.kind     = K_VALUE;
         rsp.out_byte = grp.byte1;
         rsp.method   = '0;
         rsp.last     = 1'b1;
      end else begin
         rsp.kind     = grp.kind0;
         rsp.out_byte = grp.byte0;
         rsp.method   = grp.meth0;
         rsp.last     = !grp.has2;
      end
   end

   // advance to the second result, or drop the group once its last result goes
   assign grp_done = take && (sub_ff || !grp.has2);
   assign sub_in   = take ? (!sub_ff && grp.has2) : sub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

// File: hw/rtl/http_request_header_parser_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_push / req_full    req_data  (data_byte, start_req, end_of_data)
// rsp       out        rsp_pop / rsp_empty    rsp_data  (kind, out_byte, method, last)
//
// One request byte is taken every cycle while req_full is low; the parser state
// loop settles each byte combinationally.
// A taken byte's results are registered in the group queue, then show on rsp_data in order.
// A byte that yields two results holds its queue entry for two pops.
// The four-entry group queue raises req_full when the result side stalls.
// Reset is synchronous and clears parser state and queue.
module http_request_header_parser_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  hrp_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output hrp_pkg::rsp_type rsp_data
);
   import hrp_pkg::*;

   group_type wr_grp;
   group_type rd_grp;
   qstat_type stat;
   logic      accept;
   logic      grp_done;

   assign accept    = req_push && !stat.full;
   assign req_full  = stat.full;
   assign rsp_empty = stat.empty;

   hrp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .grp    (wr_grp)
   );

   hrp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (accept),
      .wr_grp (wr_grp),
      .pop    (grp_done),
      .rd_grp (rd_grp),
      .stat   (stat)
   );

   hrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grp       (rd_grp),
      .grp_empty (stat.empty),
      .rsp_pop   (rsp_pop),
      .grp_done  (grp_done),
      .rsp       (rsp_data)
   );

`ifndef ASSERT_OFF
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_data.last)
      |=> (!rsp_empty && (rsp_data.kind == K_VALUE) && rsp_data.last))
      else $error("second result of a byte missing");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.kind == K_ERROR)) |-> rsp_data.last)
      else $error("error result not alone");

   a_method_only: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.kind != K_METHOD)) |-> (rsp_data.method == '0))
      else $error("method code on non-method result");

   a_byte_kinds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.out_byte != '0))
      |-> ((rsp_data.kind == K_URL) || (rsp_data.kind == K_VERSION)
           || (rsp_data.kind == K_NAME) || (rsp_data.kind == K_VALUE)))
      else $error("byte carried by a kind without one");
`endif

endmodule

// File: tb/http_request_header_parser_checker.sv
`timescale 1ns / 1ps
module http_request_header_parser_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  hrp_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  hrp_pkg::rsp_type rsp_data,
   output int               failures,
   output int               tags_waiting
);
   import hrp_pkg::*;

   string verb_word [8] = '{"OPTIONS", "GET", "HEAD", "POST", "PUT", "DELETE", "TRACE",
                            "CONNECT"};
   string proto_word = "HTTP/";

   phase_type   ph;
   logic [7:0]  cand;
   logic [2:0]  mpos;
   int          dcnt;
   logic        cr_held;
   logic        failed;

   rsp_type byte_tags[$];
   rsp_type tags_due[$];

   function automatic void clear_parser();
      ph = PH_METHOD;
      cand = 8'hFF;
      mpos = '0;
      dcnt = 0;
      cr_held = 1'b0;
      failed = 1'b0;
   endfunction

   function automatic void put_tag(kind_type kd, logic [7:0] b, logic [2:0] m);
      rsp_type t;
      if (byte_tags.size() >= 2) return;
      t.kind = kd;
      t.out_byte = b;
      t.method = m;
      t.last = 1'b0;
      byte_tags.push_back(t);
   endfunction

   function automatic bit decimal(logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic bit token_char(logic [7:0] b);
      string seps = "()<>@,;:\\\"/[]?={} ";
      if (b < 8'd32 || b == CH_DEL) return 1'b0;
      for (int k = 0; k < seps.len(); k++)
         if (seps[k] == b) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit take_value(logic [7:0] b);
      ph = PH_VALUE;
      if (b == CH_CR) cr_held = 1'b1;
      else put_tag(K_VALUE, b, 3'd0);
      return 1'b1;
   endfunction

   function automatic bit take_digit(logic [7:0] b);
      if (dcnt >= MAX_VERSION_DIGITS) return 1'b0;
      dcnt++;
      put_tag(K_VERSION, b, 3'd0);
      return 1'b1;
   endfunction

   function automatic bit tag_request_byte(logic [7:0] b);
      logic [7:0] keep;
      if (cr_held) begin
         cr_held = 1'b0;
         case (ph)
            PH_MIN_D: begin
               if (b != CH_LF) return 1'b0;
               ph = PH_LINE;
               return 1'b1;
            end
            PH_LINE: begin
               if (b != CH_LF) return 1'b0;
               ph = PH_DONE;
               put_tag(K_DONE, 8'h00, 3'd0);
               return 1'b1;
            end
            PH_AFTER: begin
               if (b == CH_LF) begin
                  ph = PH_SPACES;
                  return 1'b1;
               end
               put_tag(K_VALUE, CH_CR, 3'd0);
               return take_value(b);
            end
            default: begin
               if (b == CH_LF) begin
                  ph = PH_LINE;
                  put_tag(K_HDR_END, 8'h00, 3'd0);
                  return 1'b1;
               end
               put_tag(K_VALUE, CH_CR, 3'd0);
               return take_value(b);
            end
         endcase
      end
      case (ph)
         PH_METHOD: begin
            keep = 8'h00;
            for (int k = 0; k < 8; k++)
               if (cand[k] && mpos < verb_word[k].len() && verb_word[k][mpos] == b)
                  keep[k] = 1'b1;
            if (keep == 8'h00) return 1'b0;
            cand = keep;
            for (int k = 0; k < 8; k++)
               if (keep[k] && verb_word[k].len() == int'(mpos) + 1) begin
                  put_tag(K_METHOD, 8'h00, k[2:0]);
                  ph = PH_METHOD_SP;
                  return 1'b1;
               end
            mpos = mpos + 3'd1;
            return 1'b1;
         end
         PH_METHOD_SP: begin
            if (b != CH_SP) return 1'b0;
            ph = PH_URL_FIRST;
            return 1'b1;
         end
         PH_URL_FIRST, PH_URL: begin
            if (b == CH_SP) begin
               if (ph == PH_URL_FIRST) return 1'b0;
               ph = PH_HTTP;
               mpos = '0;
               return 1'b1;
            end
            put_tag(K_URL, b, 3'd0);
            ph = PH_URL;
            return 1'b1;
         end
         PH_HTTP: begin
            if (mpos > 3'd4 || proto_word[mpos] != b) return 1'b0;
            mpos = mpos + 3'd1;
            if (mpos == 3'd5) begin
               ph = PH_MAJ_S;
               dcnt = 0;
            end
            return 1'b1;
         end
         PH_MAJ_S, PH_MIN_S: begin
            if (b == CH_PLUS || b == CH_MINUS) begin
               put_tag(K_VERSION, b, 3'd0);
               ph = (ph == PH_MAJ_S) ? PH_MAJ_1 : PH_MIN_1;
               return 1'b1;
            end
            if (!decimal(b)) return 1'b0;
            ph = (ph == PH_MAJ_S) ? PH_MAJ_D : PH_MIN_D;
            return take_digit(b);
         end
         PH_MAJ_1, PH_MIN_1: begin
            if (!decimal(b)) return 1'b0;
            ph = (ph == PH_MAJ_1) ? PH_MAJ_D : PH_MIN_D;
            return take_digit(b);
         end
         PH_MAJ_D: begin
            if (decimal(b)) return take_digit(b);
            if (b != CH_DOT) return 1'b0;
            put_tag(K_VERSION, b, 3'd0);
            ph = PH_MIN_S;
            dcnt = 0;
            return 1'b1;
         end
         PH_MIN_D: begin
            if (decimal(b)) return take_digit(b);
            if (b != CH_CR) return 1'b0;
            cr_held = 1'b1;
            return 1'b1;
         end
         PH_LINE: begin
            if (b == CH_CR) begin
               cr_held = 1'b1;
               return 1'b1;
            end
            if (!token_char(b)) return 1'b0;
            put_tag(K_NAME, b, 3'd0);
            ph = PH_NAME;
            return 1'b1;
         end
         PH_NAME: begin
            if (b == CH_COLON) begin
               put_tag(K_NAME_END, 8'h00, 3'd0);
               ph = PH_AFTER;
               return 1'b1;
            end
            if (!token_char(b)) return 1'b0;
            put_tag(K_NAME, b, 3'd0);
            return 1'b1;
         end
         PH_AFTER: begin
            if (b == CH_CR) begin
               cr_held = 1'b1;
               return 1'b1;
            end
            if (b == CH_SP || b == CH_TAB) begin
               ph = PH_SPACES;
               return 1'b1;
            end
            return take_value(b);
         end
         PH_SPACES: begin
            if (b == CH_SP || b == CH_TAB) return 1'b1;
            return take_value(b);
         end
         PH_VALUE: return take_value(b);
         default: return 1'b1;
      endcase
   endfunction

   function automatic void predict_tags(req_type r);
      bit ok;
      rsp_type t;
      if (r.start_req) clear_parser();
      byte_tags.delete();
      if (failed) begin
         put_tag(K_ERROR, 8'h00, 3'd0);
      end else if (ph == PH_DONE) begin
         put_tag(K_NONE, 8'h00, 3'd0);
      end else begin
         ok = tag_request_byte(r.data_byte);
         if (!ok || (r.end_of_data && ph != PH_DONE)) failed = 1'b1;
         if (failed) begin
            byte_tags.delete();
            put_tag(K_ERROR, 8'h00, 3'd0);
         end else if (byte_tags.size() == 0) begin
            put_tag(K_NONE, 8'h00, 3'd0);
         end
      end
      foreach (byte_tags[k]) begin
         t = byte_tags[k];
         t.last = (k == byte_tags.size() - 1);
         tags_due.push_back(t);
      end
   endfunction

   task automatic report_mismatch(string what);
      if (failures < 50) $display("%0t: %s", $time, what);
      failures <= failures + 1;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_parser();
         tags_due.delete();
      end else begin
         if (req_push && !req_full) predict_tags(req_data);
         if (rsp_pop && !rsp_empty) begin
            if (tags_due.size() == 0) begin
               report_mismatch($sformatf("unexpected tag kind %0d byte %02h",
                                         rsp_data.kind, rsp_data.out_byte));
            end else begin
               want = tags_due.pop_front();
               if (rsp_data !== want)
                  report_mismatch($sformatf(
                     {"tag mismatch: got kind %0d byte %02h method %0d last %0b, ",
                      "want kind %0d byte %02h method %0d last %0b"},
                     rsp_data.kind, rsp_data.out_byte, rsp_data.method, rsp_data.last,
                     want.kind, want.out_byte, want.method, want.last));
            end
         end
      end
      tags_waiting <= tags_due.size();
   end

endmodule

// File: tb/http_request_header_parser_top_tb.sv
`timescale 1ns / 1ps
module http_request_header_parser_top_tb;
   import hrp_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int ITEM_TARGET = 450;

   typedef enum int {FLAW_NONE, FLAW_BYTE, FLAW_CUT, FLAW_DIGITS} flaw_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;
   int      failures;
   int      tags_waiting;

   req_type    stim_q[$];
   logic [7:0] req_text[$];
   bit         calm = 1'b0;
   bit         finished = 1'b0;
   int         idle_cycles = 0;

   string verb_word [8] = '{"OPTIONS", "GET", "HEAD", "POST", "PUT", "DELETE", "TRACE",
                            "CONNECT"};
   string name_pool = "abzAZ09-_.!#$%&'*+^`|~";

   always #5 clock = ~clock;

   http_request_header_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   http_request_header_parser_checker tag_checker (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .failures     (failures),
      .tags_waiting (tags_waiting)
   );

   function automatic logic [7:0] pick_byte_except(logic [7:0] a, logic [7:0] b);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
      return c;
   endfunction

   function automatic int pick_digits();
      case ($urandom_range(0, 7))
         0:       return MAX_VERSION_DIGITS;
         1:       return $urandom_range(3, MAX_VERSION_DIGITS);
         default: return $urandom_range(1, 2);
      endcase
   endfunction

   task automatic put_text(string s);
      for (int k = 0; k < s.len(); k++) req_text.push_back(s[k]);
   endtask

   task automatic put_crlf();
      req_text.push_back(CH_CR);
      req_text.push_back(CH_LF);
   endtask

   task automatic put_number(int digits);
      case ($urandom_range(0, 3))
         0:       req_text.push_back(CH_PLUS);
         1:       req_text.push_back(CH_MINUS);
         default: ;
      endcase
      repeat (digits) req_text.push_back(8'(8'h30 + $urandom_range(0, 9)));
   endtask

   task automatic put_header();
      bit fold;
      int spaces;
      fold = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 5))
         req_text.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255)) :
                            8'(name_pool[$urandom_range(0, name_pool.len() - 1)]));
      req_text.push_back(CH_COLON);
      if (fold) put_crlf();
      spaces = $urandom_range(0, 2);
      repeat (spaces) req_text.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
      repeat ($urandom_range((fold || spaces > 0) ? 0 : 1, 6)) begin
         if ($urandom_range(0, 7) == 0) begin
            req_text.push_back(CH_CR);
            req_text.push_back(pick_byte_except(CH_LF, CH_CR));
         end else begin
            req_text.push_back(pick_byte_except(CH_CR, CH_CR));
         end
      end
      put_crlf();
   endtask

   task automatic emit_text(bit opens, bit closes);
      req_type r;
      foreach (req_text[k]) begin
         r.data_byte = req_text[k];
         r.start_req = opens && (k == 0);
         r.end_of_data = closes && (k == req_text.size() - 1);
         stim_q.push_back(r);
      end
      req_text.delete();
   endtask

   task automatic build_request(int n);
      flaw_type flaw;
      int pos;
      flaw = (n < 8 || $urandom_range(0, 9) < 7) ? FLAW_NONE : flaw_type'($urandom_range(1, 3));
      put_text(verb_word[(n < 8) ? n : $urandom_range(0, 7)]);
      req_text.push_back(CH_SP);
      repeat ($urandom_range(1, 6)) req_text.push_back(pick_byte_except(CH_SP, CH_SP));
      req_text.push_back(CH_SP);
      put_text("HTTP/");
      put_number((flaw == FLAW_DIGITS) ? MAX_VERSION_DIGITS + 1 : pick_digits());
      req_text.push_back(CH_DOT);
      put_number(pick_digits());
      put_crlf();
      repeat ($urandom_range(0, 3)) put_header();
      put_crlf();
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) req_text.push_back(8'($urandom_range(0, 255)));
      if (flaw == FLAW_BYTE)
         req_text[$urandom_range(0, req_text.size() - 1)] = 8'($urandom_range(0, 255));
      if (flaw == FLAW_CUT) begin
         pos = $urandom_range(1, req_text.size() - 1);
         while (req_text.size() > pos) void'(req_text.pop_back());
      end
      emit_text(1'b1, flaw == FLAW_CUT || $urandom_range(0, 2) != 0);
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;

      put_text("PUT x HTTP/+1.-2");
      put_crlf();
      put_text("A:");
      put_crlf();
      put_crlf();
      put_crlf();
      emit_text(1'b1, 1'b1);
      req_text.push_back(8'h41);
      emit_text(1'b0, 1'b0);
      req_text.push_back(8'hFF);
      emit_text(1'b1, 1'b1);
      req_text.push_back(8'h00);
      emit_text(1'b0, 1'b0);

      for (int n = 0; stim_q.size() < ITEM_TARGET; n++) begin
         build_request(n);
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4))
               stim_q.push_back(req_type'({8'($urandom_range(0, 255)),
                                           $urandom_range(0, 7) == 0,
                                           $urandom_range(0, 7) == 0}));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim_q.size(); i++) begin
         calm = (i >= stim_q.size() * 17 / 20);
         if (!calm && $urandom_range(0, 5) == 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         req_push <= 1'b1;
         req_data <= stim_q[i];
         do @(posedge clock); while (req_full);
      end
      req_push <= 1'b0;

      @(posedge clock);
      while (tags_waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      finished = 1'b1;
      if (failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int pops;
      bit held;
      pops = 0;
      held = 1'b0;
      rsp_pop = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && pops >= 60) begin
            // hold off the reader so the queue fills and stalls the writer
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         if (!rsp_empty) pops++;
      end
   end

   always @(posedge clock) begin
      if (reset || finished || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
